[rtl/rlbp_pkg.sv]
// ----------------------------------------------------------------------------
// rlbp_pkg
// Shared types and constants of the run-level bit packer.
// ----------------------------------------------------------------------------
package rlbp_pkg;

	localparam int COEFFS_PER_BLOCK = 16;
	localparam int CIDX_W           = $clog2(COEFFS_PER_BLOCK);
	localparam int ZRUN_W           = 4;
	localparam int MAX_DIRECT       = 14;
	localparam logic [3:0] ESC_NIBBLE = 4'hF;
	localparam logic [7:0] EOB_BYTE   = 8'h00;

	localparam logic ACT_COEFF = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic               action;
		logic signed [15:0] coeff;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        run_last;
		logic        stream_end;
		logic [31:0] stream_bytes;
	} result_t;

	// bytes produced by one item, first byte in slot 0
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      nb_m1;
		logic            flush;
		logic            byte_valid;
		logic [31:0]     total;
	} tok_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/rlbp_front.sv]
// ----------------------------------------------------------------------------
// rlbp_front
// Accepts coefficients, tracks run and block position, packs token bits and
// hands completed bytes of each item to the queue as one entry.
// ----------------------------------------------------------------------------
module rlbp_front import rlbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	input  q_status_t  q_status,
	output logic       push,
	output tok_entry_t push_entry
);

	logic [CIDX_W-1:0] cidx_q;
	logic [ZRUN_W-1:0] zrun_q;
	logic [6:0]        pend_q;   // left-aligned pending bits
	logic [2:0]        pcnt_q;
	logic [31:0]       total_q;

	logic        accept;
	logic        is_flush;
	logic        nz;
	logic        neg;
	logic [16:0] mag;
	logic        direct_lvl;
	logic        blk_end;
	logic [7:0]  token;
	logic [31:0] w;
	logic [5:0]  len;
	logic [5:0]  cnt;
	logic [2:0]  nb;
	logic [39:0] acc;
	logic [39:0] left;
	logic        flush_bv;

	assign item_stall = q_status.full;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		is_flush   = item.action == ACT_FLUSH;
		nz         = item.coeff != 16'sd0;
		neg        = item.coeff[15];
		mag        = neg ? (17'd0 - {1'b1, item.coeff}) : {1'b0, item.coeff};
		direct_lvl = mag <= 17'(MAX_DIRECT);
		blk_end    = cidx_q == CIDX_W'(COEFFS_PER_BLOCK - 1);
		token      = {zrun_q, direct_lvl ? mag[3:0] : ESC_NIBBLE};
		w          = 32'd0;
		len        = 6'd0;
		if (nz) begin
			if (direct_lvl) begin
				w   = {token, neg, 23'd0};
				len = 6'd9;
			end else begin
				w   = {token, item.coeff, 8'd0};
				len = 6'd24;
			end
		end
		// end-of-block byte follows the level bits
		if (blk_end) begin
			w   = w | ({EOB_BYTE, 24'd0} >> len);
			len = len + 6'd8;
		end
		cnt  = {3'd0, pcnt_q} + len;
		nb   = cnt[5:3];
		acc  = {pend_q, 33'd0} | ({w, 8'd0} >> pcnt_q);
		left = acc << {nb, 3'b000};
		flush_bv = pcnt_q != 3'd0;

		push_entry = '0;
		if (is_flush) begin
			push_entry.bytes[0]   = {pend_q, 1'b0};
			push_entry.flush      = 1'b1;
			push_entry.byte_valid = flush_bv;
			push_entry.total      = total_q + {31'd0, flush_bv};
		end else begin
			// oldest byte sits at the top of acc and goes to slot 0
			push_entry.bytes      = {acc[15:8], acc[23:16], acc[31:24], acc[39:32]};
			push_entry.nb_m1      = 2'(nb - 3'd1);
			push_entry.byte_valid = 1'b1;
		end
		push = accept && (is_flush || nb != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cidx_q  <= '0;
			zrun_q  <= '0;
			pend_q  <= '0;
			pcnt_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			if (is_flush) begin
				cidx_q  <= '0;
				zrun_q  <= '0;
				pend_q  <= '0;
				pcnt_q  <= '0;
				total_q <= '0;
			end else begin
				pend_q  <= left[39:33];
				pcnt_q  <= cnt[2:0];
				total_q <= total_q + {29'd0, nb};
				if (blk_end) begin
					cidx_q <= '0;
					zrun_q <= '0;
				end else begin
					cidx_q <= cidx_q + 1'b1;
					zrun_q <= nz ? '0 : zrun_q + 1'b1;
				end
			end
		end
	end

endmodule

[rtl/rlbp_queue.sv]
// ----------------------------------------------------------------------------
// rlbp_queue
// Short register queue of byte entries between front and back.
// ----------------------------------------------------------------------------
module rlbp_queue import rlbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tok_entry_t push_entry,
	input  logic       pop,
	output tok_entry_t head,
	output q_status_t  status
);

	tok_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

endmodule

[rtl/rlbp_back.sv]
// ----------------------------------------------------------------------------
// rlbp_back
// Walks head entry bytes to output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module rlbp_back import rlbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tok_entry_t head,
	input  q_status_t  q_status,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	logic [1:0] idx_q;
	logic       valid_q;
	result_t    res_q;
	logic       load;
	logic       last;

	assign load = !q_status.empty && (!valid_q || !result_stall);
	assign last = idx_q == head.nb_m1;
	assign pop  = load && last;

	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last ? 2'd0 : idx_q + 2'd1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte     <= head.bytes[idx_q];
			res_q.byte_valid   <= head.byte_valid;
			res_q.run_last     <= last;
			res_q.stream_end   <= head.flush;
			res_q.stream_bytes <= head.flush ? head.total : 32'd0;
		end
	end

endmodule

[rtl/run_level_bit_packer.sv]
// ----------------------------------------------------------------------------
// run_level_bit_packer
// Run-level coder for 4x4 blocks of quantized coefficients with MSB-first
// bit packing into a byte stream.
//
// item channel: one coefficient (action coeff) or a flush per transaction.
// result channel: one stream byte per transaction; run_last marks the last
// byte caused by an item, stream_end and stream_bytes come with the flush.
// A coefficient that completes no byte gives no result transaction.
// Throughput: one item per cycle while each item yields at most one byte and
// result_stall is low; the output side moves one byte per cycle, so an item that
// completes n bytes gives n result transactions (n is 0..4).
// The first byte of an item passes through a queue entry, then the output register.
// A four-entry queue parts front and back; item_stall rises only when it
// is full, so a stalled receiver backs up into item_stall after the queue
// fills. Reset clears block position, run, pending bits and byte count.
// ----------------------------------------------------------------------------
module run_level_bit_packer import rlbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	q_status_t  q_status;
	logic       push;
	tok_entry_t push_entry;
	logic       pop;
	tok_entry_t head;

	rlbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	rlbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	rlbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// flush result always closes its item
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stream_end |-> result.run_last)
		else $error("flush result without run_last");

	// only a flush with nothing pending carries an empty byte
	a_empty_flush: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.stream_end)
		else $error("empty byte outside flush");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.stream_end |-> result.stream_bytes == 32'd0)
		else $error("byte count on coefficient result");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue both full and empty");

	// pop only when the back end loads from a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule
